// ===== hw/rtl/prrb_pkg.sv =====
// shared constants, types and configuration index codes of the packet retransmit ring buffer
package prrb_pkg;

	localparam int MAX_PACK_WORDS = 32;
	localparam int RING_DEPTH     = 64;

	localparam int WORD_W    = 64;
	localparam int NUM_W     = 32;
	localparam int PW_CFG_W  = 6;
	localparam int RP_CFG_W  = 7;
	localparam int CFG_IDX_W = 2;

	localparam int LEN_W       = $clog2(MAX_PACK_WORDS + 1);
	localparam int WPOS_W      = (MAX_PACK_WORDS > 1) ? $clog2(MAX_PACK_WORDS) : 1;
	localparam int RING_W      = $clog2(RING_DEPTH + 1);
	localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SLOTC_W     = RING_W + 1;
	localparam int OFF_W       = NUM_W + LEN_W + 3;
	localparam int HDR_W       = WORD_W + OFF_W + LEN_W;
	localparam int STORE_DEPTH = RING_DEPTH * MAX_PACK_WORDS;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam logic [CFG_IDX_W-1:0] CFG_PACK_WORDS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RING_PACKETS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SESSION_TAG  = CFG_IDX_W'(2);

	localparam logic [PW_CFG_W-1:0] PACK_WORDS_RESET   = PW_CFG_W'(32);
	localparam logic [RP_CFG_W-1:0] RING_PACKETS_RESET = RP_CFG_W'(64);

	// what the output register is loaded with
	typedef enum logic [2:0] {
		SEL_LIVE_SESSION,
		SEL_LIVE_OFFSET,
		SEL_LIVE_WORD,
		SEL_RPL_SESSION,
		SEL_RPL_OFFSET,
		SEL_RPL_DATA
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      live_start;
		logic      emit;
		emit_sel_t sel;
		logic      live_commit;
		logic      win;
		logic      slot_calc;
		logic      hdr_rd;
		logic      data_first;
		logic      data_next;
	} ctl_t;

	typedef struct packed {
		logic in_op;
		logic word_pos_zero;
		logic out_free;
		logic in_window;
		logic slot_ok;
		logic data_last;
	} sts_t;

endpackage

// ===== hw/rtl/prrb_cmd_if.sv =====
// input channel: audio words and retransmit requests
interface prrb_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [prrb_pkg::WORD_W-1:0]   audio_word;
	logic [prrb_pkg::NUM_W-1:0]    request_number;

	modport source(output valid, output op, output audio_word, output request_number,
		input ready);
	modport sink(input valid, input op, input audio_word, input request_number,
		output ready);
endinterface

// ===== hw/rtl/prrb_pkt_if.sv =====
// output channel: header and payload words of outgoing packets
interface prrb_pkt_if;
	logic                        valid;
	logic                        ready;
	logic [prrb_pkg::WORD_W-1:0] out_word;
	logic                        is_header;
	logic                        is_resend;
	logic                        last_of_packet;

	modport source(output valid, output out_word, output is_header, output is_resend,
		output last_of_packet, input ready);
	modport sink(input valid, input out_word, input is_header, input is_resend,
		input last_of_packet, output ready);
endinterface

// ===== hw/rtl/prrb_cfg_if.sv =====
// configuration write channel
interface prrb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [prrb_pkg::CFG_IDX_W-1:0] index;
	logic [prrb_pkg::WORD_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/prrb_ram.sv =====
// generic single-write, single-read ram with registered read data
module prrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/prrb_ctrl.sv =====
// sequencer for live packets and replays
module prrb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  prrb_pkg::sts_t sts,
	output prrb_pkg::ctl_t ctl
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIVE_HDR0,
		ST_LIVE_HDR1,
		ST_LIVE_WORD,
		ST_REQ_WIN,
		ST_REQ_SLOT,
		ST_REQ_CHECK,
		ST_REQ_FETCH,
		ST_RPL_HDR0,
		ST_RPL_HDR1,
		ST_RPL_DATA
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.sel  = prrb_pkg::SEL_LIVE_WORD;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (!sts.in_op) begin
						ctl.live_start = sts.word_pos_zero;
						state_d = sts.word_pos_zero ? ST_LIVE_HDR0 : ST_LIVE_WORD;
					end else begin
						state_d = ST_REQ_WIN;
					end
				end
			end
			ST_LIVE_HDR0: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = prrb_pkg::SEL_LIVE_SESSION;
					state_d  = ST_LIVE_HDR1;
				end
			end
			ST_LIVE_HDR1: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = prrb_pkg::SEL_LIVE_OFFSET;
					state_d  = ST_LIVE_WORD;
				end
			end
			ST_LIVE_WORD: begin
				if (sts.out_free) begin
					ctl.emit        = 1'b1;
					ctl.sel         = prrb_pkg::SEL_LIVE_WORD;
					ctl.live_commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_REQ_WIN: begin
				ctl.win = 1'b1;
				state_d = ST_REQ_SLOT;
			end
			ST_REQ_SLOT: begin
				if (sts.in_window) begin
					ctl.slot_calc = 1'b1;
					state_d       = ST_REQ_CHECK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REQ_CHECK: begin
				if (sts.slot_ok) begin
					ctl.hdr_rd = 1'b1;
					state_d    = ST_REQ_FETCH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REQ_FETCH: begin
				ctl.data_first = 1'b1;
				state_d        = ST_RPL_HDR0;
			end
			ST_RPL_HDR0: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = prrb_pkg::SEL_RPL_SESSION;
					state_d  = ST_RPL_HDR1;
				end
			end
			ST_RPL_HDR1: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = prrb_pkg::SEL_RPL_OFFSET;
					state_d  = ST_RPL_DATA;
				end
			end
			ST_RPL_DATA: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = prrb_pkg::SEL_RPL_DATA;
					if (sts.data_last) begin
						state_d = ST_IDLE;
					end else begin
						ctl.data_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/prrb_dp.sv =====
// datapath: configuration, packet counters, ring stores, window check and output register
module prrb_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  prrb_pkg::ctl_t                 ctl,
	output prrb_pkg::sts_t                 sts,
	input  logic                           in_op,
	input  logic [prrb_pkg::WORD_W-1:0]    in_audio_word,
	input  logic [prrb_pkg::NUM_W-1:0]     in_request_number,
	input  logic                           cfg_valid,
	input  logic [prrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prrb_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [prrb_pkg::WORD_W-1:0]    out_word,
	output logic                           out_hdr,
	output logic                           out_resend,
	output logic                           out_last
);

	// configuration
	logic [prrb_pkg::PW_CFG_W-1:0] pack_words_q;
	logic [prrb_pkg::RP_CFG_W-1:0] ring_packets_q;
	logic [prrb_pkg::WORD_W-1:0]   session_tag_q;
	logic [prrb_pkg::LEN_W-1:0]    pw_eff;
	logic [prrb_pkg::RING_W-1:0]   ring_eff;

	// live packet state
	logic [prrb_pkg::NUM_W-1:0]    packets_done_q;
	logic [prrb_pkg::SLOT_W-1:0]   write_slot_q;
	logic [prrb_pkg::WPOS_W-1:0]   word_pos_q;
	logic [prrb_pkg::RING_DEPTH-1:0] slot_valid_q;
	logic [prrb_pkg::WORD_W-1:0]   word_q;
	logic [prrb_pkg::NUM_W-1:0]    req_num_q;
	logic [prrb_pkg::WORD_W-1:0]   cur_sess_q;
	logic [prrb_pkg::OFF_W-1:0]    cur_off_q;
	logic [prrb_pkg::NUM_W+prrb_pkg::LEN_W-1:0] off_prod;
	logic [prrb_pkg::LEN_W-1:0]    live_len;
	logic                          live_last;
	logic [prrb_pkg::SLOT_W-1:0]   ws_next;

	// request lookup
	logic                          lt_q;
	logic [prrb_pkg::NUM_W-1:0]    lower_q;
	logic [prrb_pkg::RING_W-1:0]   dist_q;
	logic [prrb_pkg::SLOTC_W-1:0]  slot_q;
	logic [prrb_pkg::NUM_W-1:0]    lower;
	logic [prrb_pkg::SLOTC_W-1:0]  ws_ext;
	logic [prrb_pkg::SLOTC_W-1:0]  dist_ext;
	logic [prrb_pkg::SLOTC_W-1:0]  slot_calc;
	logic [prrb_pkg::SLOT_W-1:0]   slot_idx;
	logic [prrb_pkg::WPOS_W-1:0]   rd_idx_q;
	logic [prrb_pkg::WPOS_W-1:0]   rd_idx_nxt;

	// rams
	logic [prrb_pkg::HDR_W-1:0]    hdr_wdata;
	logic [prrb_pkg::HDR_W-1:0]    hdr_rdata;
	logic [prrb_pkg::WORD_W-1:0]   rpl_sess;
	logic [prrb_pkg::OFF_W-1:0]    rpl_off;
	logic [prrb_pkg::LEN_W-1:0]    rpl_len;
	logic                          store_re;
	logic [prrb_pkg::STORE_AW-1:0] store_waddr;
	logic [prrb_pkg::STORE_AW-1:0] store_raddr;
	logic [prrb_pkg::WORD_W-1:0]   store_rdata;

	// output register
	logic                          out_valid_q;
	logic [prrb_pkg::WORD_W-1:0]   out_word_q;
	logic                          out_hdr_q;
	logic                          out_resend_q;
	logic                          out_last_q;
	logic                          out_free;

	function automatic logic [prrb_pkg::STORE_AW-1:0] store_addr(
		input logic [prrb_pkg::SLOT_W-1:0] slot,
		input logic [prrb_pkg::WPOS_W-1:0] idx
	);
		return prrb_pkg::STORE_AW'(slot * prrb_pkg::MAX_PACK_WORDS) +
			prrb_pkg::STORE_AW'(idx);
	endfunction

	// out-of-range register values are clamped
	always_comb begin
		if (pack_words_q == '0) begin
			pw_eff = prrb_pkg::LEN_W'(1);
		end else if (32'(pack_words_q) > 32'(prrb_pkg::MAX_PACK_WORDS)) begin
			pw_eff = prrb_pkg::LEN_W'(prrb_pkg::MAX_PACK_WORDS);
		end else begin
			pw_eff = prrb_pkg::LEN_W'(pack_words_q);
		end
		if (ring_packets_q == '0) begin
			ring_eff = prrb_pkg::RING_W'(1);
		end else if (32'(ring_packets_q) > 32'(prrb_pkg::RING_DEPTH)) begin
			ring_eff = prrb_pkg::RING_W'(prrb_pkg::RING_DEPTH);
		end else begin
			ring_eff = prrb_pkg::RING_W'(ring_packets_q);
		end
	end

	assign off_prod  = packets_done_q * pw_eff;
	assign live_len  = prrb_pkg::LEN_W'(word_pos_q) + prrb_pkg::LEN_W'(1);
	assign live_last = live_len >= pw_eff;
	assign ws_next   = (prrb_pkg::RING_W'(write_slot_q) + prrb_pkg::RING_W'(1) >= ring_eff) ?
		'0 : write_slot_q + prrb_pkg::SLOT_W'(1);

	// window lower bound clamped at zero
	assign lower = (packets_done_q > prrb_pkg::NUM_W'(ring_eff)) ?
		packets_done_q - prrb_pkg::NUM_W'(ring_eff) : '0;

	assign ws_ext    = prrb_pkg::SLOTC_W'(write_slot_q);
	assign dist_ext  = prrb_pkg::SLOTC_W'(dist_q);
	assign slot_calc = (ws_ext >= dist_ext) ? ws_ext - dist_ext :
		ws_ext + prrb_pkg::SLOTC_W'(ring_eff) - dist_ext;
	assign slot_idx  = slot_q[prrb_pkg::SLOT_W-1:0];

	assign rpl_sess = hdr_rdata[prrb_pkg::HDR_W-1 -: prrb_pkg::WORD_W];
	assign rpl_off  = hdr_rdata[prrb_pkg::LEN_W +: prrb_pkg::OFF_W];
	assign rpl_len  = hdr_rdata[prrb_pkg::LEN_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts.in_op         = in_op;
		sts.word_pos_zero = (word_pos_q == '0);
		sts.out_free      = out_free;
		sts.in_window     = lt_q && (req_num_q >= lower_q);
		// a slot still being refilled or never completed is not replayed
		sts.slot_ok       = (slot_q < prrb_pkg::SLOTC_W'(prrb_pkg::RING_DEPTH)) &&
			slot_valid_q[slot_idx] && !((word_pos_q != '0) && (slot_idx == write_slot_q));
		sts.data_last     = (prrb_pkg::LEN_W'(rd_idx_q) + prrb_pkg::LEN_W'(1)) == rpl_len;
	end

	assign hdr_wdata   = {cur_sess_q, cur_off_q, live_len};
	assign rd_idx_nxt  = ctl.data_first ? '0 : rd_idx_q + prrb_pkg::WPOS_W'(1);
	assign store_re    = ctl.data_first || ctl.data_next;
	assign store_waddr = store_addr(write_slot_q, word_pos_q);
	assign store_raddr = store_addr(slot_idx, rd_idx_nxt);

	prrb_ram #(
		.WIDTH(prrb_pkg::HDR_W),
		.DEPTH(prrb_pkg::RING_DEPTH)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ctl.live_commit && live_last),
		.waddr(write_slot_q),
		.wdata(hdr_wdata),
		.re   (ctl.hdr_rd),
		.raddr(slot_idx),
		.rdata(hdr_rdata)
	);

	prrb_ram #(
		.WIDTH(prrb_pkg::WORD_W),
		.DEPTH(prrb_pkg::STORE_DEPTH)
	) u_store_ram (
		.clk  (clk),
		.we   (ctl.live_commit),
		.waddr(store_waddr),
		.wdata(word_q),
		.re   (store_re),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_words_q   <= prrb_pkg::PACK_WORDS_RESET;
			ring_packets_q <= prrb_pkg::RING_PACKETS_RESET;
			session_tag_q  <= '0;
			packets_done_q <= '0;
			write_slot_q   <= '0;
			word_pos_q     <= '0;
			slot_valid_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					prrb_pkg::CFG_PACK_WORDS: begin
						pack_words_q <= cfg_data[prrb_pkg::PW_CFG_W-1:0];
					end
					prrb_pkg::CFG_RING_PACKETS: begin
						ring_packets_q <= cfg_data[prrb_pkg::RP_CFG_W-1:0];
					end
					prrb_pkg::CFG_SESSION_TAG: begin
						session_tag_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (ctl.live_start) begin
				slot_valid_q[write_slot_q] <= 1'b0;
			end
			if (ctl.live_commit) begin
				if (live_last) begin
					slot_valid_q[write_slot_q] <= 1'b1;
					word_pos_q     <= '0;
					write_slot_q   <= ws_next;
					packets_done_q <= packets_done_q + prrb_pkg::NUM_W'(1);
				end else begin
					word_pos_q <= word_pos_q + prrb_pkg::WPOS_W'(1);
				end
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			word_q    <= in_audio_word;
			req_num_q <= in_request_number;
		end
		if (ctl.live_start) begin
			cur_sess_q <= session_tag_q;
			cur_off_q  <= {off_prod, 3'b000};
		end
		if (ctl.win) begin
			lt_q    <= req_num_q < packets_done_q;
			lower_q <= lower;
			dist_q  <= prrb_pkg::RING_W'(packets_done_q - req_num_q);
		end
		if (ctl.slot_calc) begin
			slot_q <= slot_calc;
		end
		if (store_re) begin
			rd_idx_q <= rd_idx_nxt;
		end
		if (ctl.emit) begin
			unique case (ctl.sel)
				prrb_pkg::SEL_LIVE_SESSION: begin
					out_word_q   <= cur_sess_q;
					out_hdr_q    <= 1'b1;
					out_resend_q <= 1'b0;
					out_last_q   <= 1'b0;
				end
				prrb_pkg::SEL_LIVE_OFFSET: begin
					out_word_q   <= prrb_pkg::WORD_W'(cur_off_q);
					out_hdr_q    <= 1'b1;
					out_resend_q <= 1'b0;
					out_last_q   <= 1'b0;
				end
				prrb_pkg::SEL_LIVE_WORD: begin
					out_word_q   <= word_q;
					out_hdr_q    <= 1'b0;
					out_resend_q <= 1'b0;
					out_last_q   <= live_last;
				end
				prrb_pkg::SEL_RPL_SESSION: begin
					out_word_q   <= rpl_sess;
					out_hdr_q    <= 1'b1;
					out_resend_q <= 1'b1;
					out_last_q   <= 1'b0;
				end
				prrb_pkg::SEL_RPL_OFFSET: begin
					out_word_q   <= prrb_pkg::WORD_W'(rpl_off);
					out_hdr_q    <= 1'b1;
					out_resend_q <= 1'b1;
					out_last_q   <= 1'b0;
				end
				prrb_pkg::SEL_RPL_DATA: begin
					out_word_q   <= store_rdata;
					out_hdr_q    <= 1'b0;
					out_resend_q <= 1'b1;
					out_last_q   <= sts.data_last;
				end
				default: begin
					out_word_q   <= '0;
					out_hdr_q    <= 1'b0;
					out_resend_q <= 1'b0;
					out_last_q   <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;
	assign out_hdr    = out_hdr_q;
	assign out_resend = out_resend_q;
	assign out_last   = out_last_q;

endmodule

// ===== hw/rtl/packet_retransmit_ring_buffer_core.sv =====
// Packet retransmit ring buffer, top level. Audio words pass straight out and are kept
// in a ring of the last ring_packets packets; the first word of each packet is preceded
// by two header words (session tag, then byte offset). A live audio word yields one
// result word, three when it opens a packet, each through the single output register
// once it is free. A retransmit request runs the window check, slot arithmetic and
// header ram read, then streams two header words and one payload word per cycle, while
// the output register is free, out of the payload ram, read one word ahead; a request
// outside the window, or for a slot still refilling or never completed, gives no output.
// One item is in work at a time; the next is taken once the last result of the previous
// one sits in the output register, or a rejected request is back in idle. The payload
// and header rams are not cleared after reset: per-slot valid flops mark which slots
// hold a completed packet, so no clearing pass is needed. Configuration writes are
// always taken and must only be issued while the block is idle.
module packet_retransmit_ring_buffer_core (
	input logic        clk,
	input logic        arst_n,
	prrb_cmd_if.sink   cmd,
	prrb_pkt_if.source pkt,
	prrb_cfg_if.sink   cfg
);

	prrb_pkg::ctl_t ctl;
	prrb_pkg::sts_t sts;
	logic           in_ready;

	prrb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.ctl     (ctl)
	);

	prrb_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.in_op            (cmd.op),
		.in_audio_word    (cmd.audio_word),
		.in_request_number(cmd.request_number),
		.cfg_valid        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.out_ready        (pkt.ready),
		.out_valid        (pkt.valid),
		.out_word         (pkt.out_word),
		.out_hdr          (pkt.is_header),
		.out_resend       (pkt.is_resend),
		.out_last         (pkt.last_of_packet)
	);

	assign cmd.ready = in_ready;
	assign cfg.ready = 1'b1;

`ifndef SYNTHESIS
	// the output register is only loaded once the previous item has left
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!pkt.valid || pkt.ready))
		else $error("output register overwritten while holding an item");

	// every accepted item keeps the block busy in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("new item taken straight after accept");

	// the first replay payload read only follows a successful slot check
	a_fetch_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.data_first |-> $past(ctl.hdr_rd))
		else $error("payload fetch without header read");
`endif

endmodule
